### sv/mbpu_pkg.sv
// Shared types and constants for the mono bitmap header and pixel unpacker.
// No dependencies; every other file of the block imports this package.
package mbpu_pkg;

  localparam int unsigned HEADER_BYTES = 9;
  localparam int unsigned HDR_CNT_W    = 4;
  localparam int unsigned DIM_W        = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BIT_IDX_W    = 3;
  localparam logic [BYTE_W-1:0] DEPTH_ONE = 8'd1;
  localparam logic [HDR_CNT_W-1:0] DEPTH_IDX = HDR_CNT_W'(HEADER_BYTES - 1);
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_SMALL = 2'd1,
    KIND_DEPTH = 2'd2,
    KIND_OOB   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_IGNORE
  } phase_t;

  typedef enum logic [1:0] {
    CMD_ERR,
    CMD_START,
    CMD_PIX
  } cmd_t;

  // One queue entry from the front to the back.
  typedef struct packed {
    cmd_t              cmd;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } entry_t;

  // One result as it leaves the back.
  typedef struct packed {
    logic  image_end;
    logic  row_end;
    logic  pixel_value;
    kind_t kind;
  } result_t;

endpackage

### sv/mbpu_front.sv
// Front of the unpacker: accepts buffer bytes, parses the header and
// pushes error, start and pixel-byte commands. Depends on mbpu_pkg.
module mbpu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] data_byte
  input  logic            s_tlast,   // end_of_buffer
  input  logic            q_full,
  output logic            q_push,
  output mbpu_pkg::entry_t q_entry
);
  import mbpu_pkg::*;

  phase_t               phase, phase_next;
  logic [HDR_CNT_W-1:0] hcount, hcount_next;
  logic [DIM_W-1:0]     width;
  logic [DIM_W-1:0]     height;
  logic                 acc;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      hcount <= '0;
    end else begin
      phase  <= phase_next;
      hcount <= hcount_next;
    end
  end

  // Assemble the little-endian dimensions.
  always_ff @(posedge clk) begin
    if (acc && phase == PH_HEADER) begin
      if (!hcount[3] && !hcount[2]) begin
        width[hcount[1:0]*BYTE_W +: BYTE_W] <= s_tdata;
      end else if (!hcount[3]) begin
        height[hcount[1:0]*BYTE_W +: BYTE_W] <= s_tdata;
      end
    end
  end

  always_comb begin
    phase_next     = phase;
    hcount_next    = hcount;
    q_push         = 1'b0;
    q_entry.cmd    = CMD_PIX;
    q_entry.kind   = KIND_PIXEL;
    q_entry.data   = s_tdata;
    q_entry.last   = s_tlast;
    q_entry.width  = width;
    q_entry.height = height;
    if (acc) begin
      unique case (phase)
        PH_HEADER: begin
          hcount_next = hcount + 1'b1;
          if (hcount == DEPTH_IDX) begin
            if (s_tdata != DEPTH_ONE) begin
              q_push       = 1'b1;
              q_entry.cmd  = CMD_ERR;
              q_entry.kind = KIND_DEPTH;
              phase_next   = PH_IGNORE;
            end else if (width == '0 || height == '0) begin
              phase_next = PH_IGNORE;
            end else begin
              q_push      = 1'b1;
              q_entry.cmd = CMD_START;
              phase_next  = PH_PIXELS;
            end
          end else if (s_tlast) begin
            q_push       = 1'b1;
            q_entry.cmd  = CMD_ERR;
            q_entry.kind = KIND_SMALL;
          end
        end
        PH_PIXELS: begin
          q_push = 1'b1;
        end
        PH_IGNORE: begin
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
      // The next byte opens a new buffer.
      if (s_tlast) begin
        phase_next  = PH_HEADER;
        hcount_next = '0;
      end
    end
  end

endmodule

### sv/mbpu_fifo.sv
// Short command queue between front and back, built from flip-flops.
// Depends on mbpu_pkg for the entry type.
module mbpu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mbpu_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output mbpu_pkg::entry_t rd_entry
);
  import mbpu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

### sv/mbpu_back.sv
// Back of the unpacker: expands queued commands into results, one per
// cycle while m_tready allows, tracking row and column. Depends on mbpu_pkg.
module mbpu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  mbpu_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,  // [1:0] result_kind, [2] pixel_value,
                                     // [3] row_end, [4] image_end, [7:5] zero
  output logic             m_tlast   // last_in_run
);
  import mbpu_pkg::*;

  entry_t                cur;
  logic                  busy;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic                  tail;
  logic                  active;
  logic [DIM_W-1:0]      col;
  logic [DIM_W-1:0]      row;
  logic [DIM_W-1:0]      wm1;
  logic [DIM_W-1:0]      hm1;
  result_t               res;

  logic can_emit, step, emit, done, lst, re, ie, set_tail, pix_step;

  assign can_emit = !m_tvalid || m_tready;
  assign step     = busy && can_emit;
  assign re       = (col == wm1);
  assign ie       = re && (row == hm1);
  assign pix_step = step && (cur.cmd == CMD_PIX) && !tail && active;

  always_comb begin
    emit            = 1'b0;
    done            = 1'b0;
    lst             = 1'b0;
    set_tail        = 1'b0;
    res.kind        = KIND_PIXEL;
    res.pixel_value = 1'b0;
    res.row_end     = 1'b0;
    res.image_end   = 1'b0;
    unique case (cur.cmd)
      CMD_ERR: begin
        emit     = 1'b1;
        res.kind = cur.kind;
        lst      = 1'b1;
        done     = 1'b1;
      end
      CMD_START: begin
        done = 1'b1;
        if (cur.last) begin
          emit     = 1'b1;
          res.kind = KIND_OOB;
          lst      = 1'b1;
        end
      end
      CMD_PIX: begin
        if (tail) begin
          emit     = 1'b1;
          res.kind = KIND_OOB;
          lst      = 1'b1;
          done     = 1'b1;
        end else if (!active) begin
          // Drop bytes past the end of the image.
          done = 1'b1;
        end else begin
          emit            = 1'b1;
          res.pixel_value = !cur.data[LAST_BIT - bit_idx];
          res.row_end     = re;
          res.image_end   = ie;
          if (ie) begin
            lst  = 1'b1;
            done = 1'b1;
          end else if (bit_idx == LAST_BIT) begin
            if (cur.last) begin
              set_tail = 1'b1;
            end else begin
              lst  = 1'b1;
              done = 1'b1;
            end
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign q_pop = q_valid && (!busy || (step && done));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      active <= 1'b0;
      tail   <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (step && done) begin
        busy <= 1'b0;
      end
      if (q_pop) begin
        tail <= 1'b0;
      end else if (pix_step) begin
        tail <= set_tail;
      end
      if (step && cur.cmd == CMD_START) begin
        active <= !cur.last;
      end else if (pix_step && (ie || set_tail)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && cur.cmd == CMD_START) begin
      wm1 <= cur.width - 1'b1;
      hm1 <= cur.height - 1'b1;
      col <= '0;
      row <= '0;
    end else if (pix_step) begin
      if (re) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (q_pop) begin
      bit_idx <= '0;
    end else if (pix_step) begin
      bit_idx <= bit_idx + 1'b1;
    end
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  // Output register: holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_emit) begin
      m_tvalid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit) begin
      m_tdata <= {3'b000, res};
      m_tlast <= lst;
    end
  end

endmodule

### sv/mono_bitmap_header_and_pixel_unpacker.sv
// Mono bitmap unpacker: takes a byte stream with a 9-byte header
// (32-bit width, 32-bit height, depth byte) followed by 1-bit pixels.
// Usage:
//   Slave channel s_*: one buffer byte per request in s_tdata, s_tlast on
//   the final byte of the buffer. The byte after a tlast starts a new
//   buffer with a new header.
//   Master channel m_*: one result per request. m_tdata carries the kind
//   (pixel, buffer too small, unsupported depth, pixel data out of bounds)
//   and the inverted pixel with row-end and image-end marks; m_tlast marks
//   the last result caused by one input byte.
// Timing:
//   The first result of a byte passes the queue, the back end's entry and
//   output registers. A pixel byte yields up to eight results, one per
//   cycle while m_tready allows, and is finished before the next is popped,
//   so the single result per cycle sets the pixel data rate. A queued byte
//   that yields no result still takes a back-end step. A FIFO_DEPTH-entry
//   queue lets the input keep taking bytes while results drain.
// Reset clears the parser, queue and output valid. When m_tready is low the
// result holds, the back end stalls and s_tready drops once the queue fills.
module mono_bitmap_header_and_pixel_unpacker #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_buffer
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [1:0] result_kind, [2] pixel_value,
                                // [3] row_end, [4] image_end, [7:5] zero
  output logic       m_tlast    // last_in_run
);
  import mbpu_pkg::*;

  entry_t push_entry;
  entry_t pop_entry;
  logic   q_full, q_push, q_pop, q_valid;

  mbpu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  mbpu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (push_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_entry (pop_entry)
  );

  mbpu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### sv/mbpu_checker.sv
// Port-level checks on the unpacker's result stream, bound to the top level.
// Depends on mbpu_pkg and mono_bitmap_header_and_pixel_unpacker.
module mbpu_stream_checks (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);
  import mbpu_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != KIND_PIXEL |-> m_tlast)
    else $error("error result not last of its byte");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != KIND_PIXEL |-> m_tdata[7:2] == '0)
    else $error("error result carries pixel fields");

  a_img_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3] && m_tlast)
    else $error("image end without row end or run end");

endmodule

bind mono_bitmap_header_and_pixel_unpacker mbpu_stream_checks u_mbpu_stream_checks (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
